FILE: hw/rtl/ffsr_pkg.sv
`timescale 1ns / 1ps

package ffsr_pkg;

  // default sizes
  localparam int TIME_SLOTS_DEF = 1024;
  localparam int TRAYS_DEF      = 256;

  // field widths
  localparam int TRAY_W = 8;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 10;
  // window arithmetic: planting start + bound + duration stays below 4096
  localparam int CALC_W = 12;
  // free run length, up to duration + 1
  localparam int RUN_W  = 11;

  localparam logic [SLOT_W-1:0] HORIZON_RST = 10'd1023;
  localparam int                SLOT_MAX    = (1 << SLOT_W) - 1;

  // task kinds
  localparam logic [KIND_W-1:0] KIND_NORMAL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PLANTING = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HARVEST  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SETUP,
    ST_SCAN,
    ST_MARK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
    logic setup;
    logic scan;
    logic mark;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_found;
    logic scan_miss;
    logic mark_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/ffsr_req_if.sv
`timescale 1ns / 1ps

interface ffsr_req_if;
  logic                                valid;
  logic                                ready;
  logic [ffsr_pkg::TRAY_W-1:0]         tray_index;
  logic [ffsr_pkg::KIND_W-1:0]         task_kind;
  logic [ffsr_pkg::SLOT_W-1:0]         rel_earliest;
  logic [ffsr_pkg::SLOT_W-1:0]         rel_latest;
  logic [ffsr_pkg::SLOT_W-1:0]         fallback_earliest;
  logic [ffsr_pkg::SLOT_W-1:0]         fallback_latest;
  logic [ffsr_pkg::SLOT_W-1:0]         duration;

  modport source (
    output valid, tray_index, task_kind, rel_earliest, rel_latest,
           fallback_earliest, fallback_latest, duration,
    input  ready
  );

  modport sink (
    input  valid, tray_index, task_kind, rel_earliest, rel_latest,
           fallback_earliest, fallback_latest, duration,
    output ready
  );
endinterface

FILE: hw/rtl/ffsr_rsp_if.sv
`timescale 1ns / 1ps

interface ffsr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        placed;
  logic [ffsr_pkg::SLOT_W-1:0] start_slot;

  modport source (
    output valid, placed, start_slot,
    input  ready
  );

  modport sink (
    input  valid, placed, start_slot,
    output ready
  );
endinterface

FILE: hw/rtl/ffsr_ctrl.sv
`timescale 1ns / 1ps

module ffsr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ffsr_pkg::sts_t sts,
  output ffsr_pkg::cmd_t cmd
);

  ffsr_pkg::state_t state;
  ffsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffsr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ffsr_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = ffsr_pkg::ST_IDLE;
        end
      end
      ffsr_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ffsr_pkg::ST_LOOKUP;
        end
      end
      ffsr_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ffsr_pkg::ST_SETUP;
      end
      ffsr_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ffsr_pkg::ST_SCAN;
      end
      ffsr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_found) begin
          state_next = ffsr_pkg::ST_MARK;
        end else if (sts.scan_miss) begin
          state_next = ffsr_pkg::ST_RESULT;
        end
      end
      ffsr_pkg::ST_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_done) begin
          state_next = ffsr_pkg::ST_RESULT;
        end
      end
      ffsr_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ffsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffsr_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ffsr_dp.sv
`timescale 1ns / 1ps

module ffsr_dp #(
  parameter int TIME_SLOTS = ffsr_pkg::TIME_SLOTS_DEF,
  parameter int TRAYS      = ffsr_pkg::TRAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffsr_pkg::cmd_t                cmd,
  output ffsr_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [ffsr_pkg::SLOT_W-1:0]   cfg_wdata,
  input  logic [ffsr_pkg::TRAY_W-1:0]   in_tray_index,
  input  logic [ffsr_pkg::KIND_W-1:0]   in_task_kind,
  input  logic [ffsr_pkg::SLOT_W-1:0]   in_rel_earliest,
  input  logic [ffsr_pkg::SLOT_W-1:0]   in_rel_latest,
  input  logic [ffsr_pkg::SLOT_W-1:0]   in_fallback_earliest,
  input  logic [ffsr_pkg::SLOT_W-1:0]   in_fallback_latest,
  input  logic [ffsr_pkg::SLOT_W-1:0]   in_duration,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_placed,
  output logic [ffsr_pkg::SLOT_W-1:0]   out_start_slot
);

  localparam int SLOT_W    = ffsr_pkg::SLOT_W;
  localparam int CALC_W    = ffsr_pkg::CALC_W;
  localparam int RUN_W     = ffsr_pkg::RUN_W;
  localparam int SLOT_AW   = $clog2(TIME_SLOTS);
  localparam int PLANT_AW  = $clog2(TRAYS);
  localparam int CLR_DEPTH = (TIME_SLOTS > TRAYS) ? TIME_SLOTS : TRAYS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int SLOT_TOP  = (TIME_SLOTS - 1 < ffsr_pkg::SLOT_MAX) ?
                             TIME_SLOTS - 1 : ffsr_pkg::SLOT_MAX;
  localparam logic [SLOT_W-1:0] SLOT_TOP_V = SLOT_W'(SLOT_TOP);
  localparam logic [CLR_W-1:0]  CLR_LAST   = CLR_W'(CLR_DEPTH - 1);

  // memories
  logic                busy_mem [TIME_SLOTS];
  logic                pv_mem   [TRAYS];
  logic [SLOT_W-1:0]   ps_mem   [TRAYS];

  logic [SLOT_W-1:0]   horizon;
  logic [CLR_W-1:0]    clr;

  // latched request
  logic [ffsr_pkg::TRAY_W-1:0] tray;
  logic [ffsr_pkg::KIND_W-1:0] kind;
  logic [SLOT_W-1:0]   rel_e;
  logic [SLOT_W-1:0]   rel_l;
  logic [SLOT_W-1:0]   fb_e;
  logic [SLOT_W-1:0]   fb_l;
  logic [SLOT_W-1:0]   dur;
  logic                pv_q;
  logic [SLOT_W-1:0]   ps_q;

  // window and scan
  logic [CALC_W-1:0]   ws;
  logic [CALC_W-1:0]   we;
  logic [CALC_W-1:0]   last;
  logic                empty;
  logic [CALC_W-1:0]   rd_addr;
  logic [CALC_W-1:0]   rd_slot;
  logic                rd_live;
  logic                rd_busy;
  logic [RUN_W-1:0]    run;
  logic                found;
  logic [CALC_W-1:0]   k;
  logic [CALC_W-1:0]   mark_addr;
  logic [CALC_W-1:0]   mark_end;

  logic [SLOT_W-1:0]   lim;
  logic                tray_ok;
  logic                planting;
  logic                issue;
  logic                hit;
  logic [CALC_W-1:0]   k_now;
  logic [CALC_W-1:0]   we_end;
  logic                plant_wr;
  logic                busy_we;
  logic [SLOT_AW-1:0]  busy_waddr;
  logic                pv_we;
  logic [PLANT_AW-1:0] pv_waddr;
  logic [PLANT_AW-1:0] tray_addr;

  assign lim       = (horizon > SLOT_TOP_V) ? SLOT_TOP_V : horizon;
  assign tray_ok   = 32'(tray) < TRAYS;
  assign planting  = kind == ffsr_pkg::KIND_PLANTING;
  assign tray_addr = PLANT_AW'(tray);
  assign issue     = cmd.scan && !empty && (rd_addr <= last);
  assign hit       = cmd.scan && rd_live && !rd_busy && (run == RUN_W'(dur));
  assign k_now     = rd_slot - CALC_W'(dur);
  assign we_end    = we + CALC_W'(dur);
  assign plant_wr  = hit && planting && tray_ok;

  assign busy_we    = (cmd.clear && (32'(clr) < TIME_SLOTS)) || cmd.mark;
  assign busy_waddr = cmd.mark ? SLOT_AW'(mark_addr) : SLOT_AW'(clr);
  assign pv_we      = (cmd.clear && (32'(clr) < TRAYS)) || plant_wr;
  assign pv_waddr   = plant_wr ? tray_addr : PLANT_AW'(clr);

  assign sts.clear_done = clr == CLR_LAST;
  assign sts.scan_found = hit;
  assign sts.scan_miss  = !issue && !rd_live;
  assign sts.mark_done  = mark_addr == mark_end;
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (busy_we) begin
      busy_mem[busy_waddr] <= cmd.mark;
    end
    if (issue) begin
      rd_busy <= busy_mem[SLOT_AW'(rd_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      pv_mem[pv_waddr] <= plant_wr;
    end
    if (plant_wr) begin
      ps_mem[tray_addr] <= k_now[SLOT_W-1:0];
    end
    if (cmd.accept) begin
      pv_q <= pv_mem[PLANT_AW'(in_tray_index)];
      ps_q <= ps_mem[PLANT_AW'(in_tray_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      horizon   <= ffsr_pkg::HORIZON_RST;
      clr       <= '0;
      rd_live   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        horizon <= cfg_wdata;
      end
      if (cmd.clear && !sts.clear_done) begin
        clr <= clr + CLR_W'(1);
      end
      rd_live <= issue;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tray  <= in_tray_index;
      kind  <= in_task_kind;
      rel_e <= in_rel_earliest;
      rel_l <= in_rel_latest;
      fb_e  <= in_fallback_earliest;
      fb_l  <= in_fallback_latest;
      dur   <= in_duration;
    end
    if (cmd.lookup) begin
      if (planting) begin
        ws <= CALC_W'(rel_e);
        we <= CALC_W'(rel_l);
      end else if (tray_ok && pv_q) begin
        ws <= CALC_W'(ps_q) + CALC_W'(rel_e);
        we <= CALC_W'(ps_q) + CALC_W'(rel_l);
      end else begin
        ws <= CALC_W'(fb_e);
        we <= CALC_W'(fb_l);
      end
    end
    if (cmd.setup) begin
      rd_addr <= ws;
      empty   <= ws > we;
      last    <= (we_end > CALC_W'(lim)) ? CALC_W'(lim) : we_end;
      run     <= '0;
      found   <= 1'b0;
    end
    if (issue) begin
      rd_addr <= rd_addr + CALC_W'(1);
      rd_slot <= rd_addr;
    end
    if (cmd.scan && rd_live) begin
      run <= rd_busy ? '0 : run + RUN_W'(1);
    end
    if (hit) begin
      found     <= 1'b1;
      k         <= k_now;
      mark_addr <= k_now;
      mark_end  <= rd_slot;
    end
    if (cmd.mark) begin
      mark_addr <= mark_addr + CALC_W'(1);
    end
    if (cmd.load) begin
      out_placed     <= found;
      out_start_slot <= found ? k[SLOT_W-1:0] : '0;
    end
  end

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // the chosen start never lies before the window opens
  a_hit_in_window: assert property (@(posedge clk) disable iff (rst)
    hit |-> (k_now >= ws))
    else $error("start before window");

  // reservations stay inside the horizon
  a_mark_in_horizon: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |-> (mark_addr <= CALC_W'(lim)))
    else $error("mark past horizon");

  // read data only returns for reads issued during a scan
  a_live_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> $past(cmd.scan))
    else $error("stray slot read");

endmodule

FILE: hw/rtl/first_fit_slot_reservation_core.sv
`timescale 1ns / 1ps

// First-fit slot reservation: one task request at a time, in the order the
// requests arrive. The earliest start in the task's window whose start slot
// and the duration slots after it are all free and inside the horizon is
// reserved and returned. After reset the core clears its busy and planting
// tables, one entry per cycle, before it accepts a request. A request then
// passes accept, lookup and setup before the scan, and result load after it.
// The scan reads one slot of the busy table per cycle, from the window start
// up to the end of the first free run long enough for the task, or to the
// last slot that a fit can reach; it ends without a read when no slot is in
// range. When placed, the start slot and the duration slots after it are
// marked busy. The busy table's one read port sets the scan rate and its one
// write port the mark rate. A finished result waits in an output register
// while the next request is taken in; a request that finishes while that
// register is still full waits until it frees.
module first_fit_slot_reservation_core #(
  parameter int TIME_SLOTS = ffsr_pkg::TIME_SLOTS_DEF,
  parameter int TRAYS      = ffsr_pkg::TRAYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ffsr_pkg::SLOT_W-1:0] cfg_wdata,
  ffsr_req_if.sink                    req,
  ffsr_rsp_if.source                  rsp
);

  ffsr_pkg::cmd_t cmd;
  ffsr_pkg::sts_t sts;

  ffsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffsr_dp #(
    .TIME_SLOTS (TIME_SLOTS),
    .TRAYS      (TRAYS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_tray_index        (req.tray_index),
    .in_task_kind         (req.task_kind),
    .in_rel_earliest      (req.rel_earliest),
    .in_rel_latest        (req.rel_latest),
    .in_fallback_earliest (req.fallback_earliest),
    .in_fallback_latest   (req.fallback_latest),
    .in_duration          (req.duration),
    .out_ready            (rsp.ready),
    .out_valid            (rsp.valid),
    .out_placed           (rsp.placed),
    .out_start_slot       (rsp.start_slot)
  );

endmodule
